// ===== rtl/assert_macros.svh =====
// Assertion macros shared by the PLL search RTL.
// No dependencies; included by the files that carry assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property under a clock, disabled while reset is asserted.
`define PMDS_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("pmds assertion failed");

// Same-cycle implication under a clock.
`define PMDS_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("pmds implication failed");

`endif

// ===== rtl/pmds_pkg.sv =====
// Package for the PLL multiplier/divider search: constants, state enum, divider structs.
// No dependencies; imported by pmds_div, pll_mul_div_search_unit, the checker and the testbench.
`default_nettype none

package pmds_pkg;

  localparam int unsigned DivW      = 32;
  localparam int unsigned CntW      = $clog2(DivW);
  localparam int unsigned MainW     = 26;
  localparam int unsigned RateW     = 28;
  localparam int unsigned CodeW     = 6;
  localparam int unsigned DvdW      = 8;
  localparam int unsigned WordW     = 30;

  localparam logic [MainW-1:0] MainRateReset = MainW'(12000000);
  localparam logic [CodeW-1:0] MulFirst      = CodeW'(7);
  localparam logic [CodeW-1:0] MulLast       = CodeW'(62);
  localparam logic [DivW-1:0]  DivMax        = DivW'(255);
  localparam logic [DivW-1:0]  RateMin       = DivW'(80000000);
  localparam logic [DivW-1:0]  RateMax       = DivW'(240000000);
  localparam logic [7:0]       StartupCount  = 8'd5;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_Q1,
    ST_W1,
    ST_Q2,
    ST_W2,
    ST_NEXT,
    ST_DONE
  } state_e;

  typedef struct packed {
    logic            start;
    logic [DivW-1:0] dividend;
    logic [DivW-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic            done;
    logic [DivW-1:0] quot;
  } div_rsp_t;

endpackage

`default_nettype wire

// ===== rtl/pmds_div.sv =====
// Shared restoring divider, one quotient bit per cycle.
// Depends on pmds_pkg and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"

module pmds_div import pmds_pkg::*; (
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire div_req_t req_i,
  output div_rsp_t      rsp_o
);

  logic            busy_q, busy_d;
  logic            done_q, done_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic [DivW-1:0] rem_q, rem_d;
  logic [DivW-1:0] quot_q, quot_d;
  logic [DivW-1:0] dvs_q, dvs_d;
  logic [DivW:0]   rem_sh;
  logic [DivW:0]   diff;
  logic            ge;

  always_comb begin
    rem_sh = {rem_q, quot_q[DivW-1]};
    diff   = rem_sh - {1'b0, dvs_q};
    ge     = rem_sh >= {1'b0, dvs_q};
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    quot_d = quot_q;
    dvs_d  = dvs_q;
    if (req_i.start) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      rem_d  = '0;
      quot_d = req_i.dividend;
      dvs_d  = req_i.divisor;
    end else if (busy_q) begin
      rem_d  = ge ? diff[DivW-1:0] : rem_sh[DivW-1:0];
      quot_d = {quot_q[DivW-2:0], ge};
      cnt_d  = cnt_q + 1'b1;
      if (cnt_q == CntW'(DivW - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q  <= rem_d;
    quot_q <= quot_d;
    dvs_q  <= dvs_d;
  end

  assign rsp_o.done = done_q;
  assign rsp_o.quot = quot_q;

  `PMDS_ASSERT_IMP(a_start_idle, clk_i, rst_ni, req_i.start, !busy_q)
  `PMDS_ASSERT_IMP(a_done_after_busy, clk_i, rst_ni, done_q, !busy_q && $past(busy_q))
  `PMDS_ASSERT(a_busy_ends, clk_i, rst_ni, $fell(busy_q) |-> done_q)

endmodule

`default_nettype wire

// ===== rtl/pll_mul_div_search_unit.sv =====
// Sequence: a target outside 80 to 240 MHz goes straight to loading the result; otherwise
// up to 56 multiplier codes are tried, each with up to two divisions on the one shared
// restoring divider plus a step state, and the result is loaded once the output is free.
// Throughput: one item at a time; a new item is taken while a result waits.
// Reset: main clock rate returns to 12 MHz, sequencer idle, no result held.
`default_nettype none
`include "assert_macros.svh"

module pll_mul_div_search_unit import pmds_pkg::*; (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             cfg_we_i,
  input  wire logic [MainW-1:0] cfg_wdata_i,
  input  wire logic             s_axis_tvalid,
  output logic                  s_axis_tready,
  input  wire logic [31:0]      s_axis_tdata,  // [31:0] target_rate
  input  wire logic             s_axis_tuser,  // [0] pll_a_select
  output logic                  m_axis_tvalid,
  input  wire logic             m_axis_tready,
  output logic [71:0]           m_axis_tdata,  // [27:0] achieved_rate, [33:28] multiplier,
                                               // [41:34] divider, [71:42] settings_word
  output logic                  m_axis_tuser   // [0] found
);

  state_e           state_q, state_d;
  logic [MainW-1:0] mcr_q;
  logic [DivW-1:0]  target_q, target_d;
  logic             sel_q, sel_d;
  logic [CodeW-1:0] code_q, code_d;
  logic [DivW-1:0]  prod_q, prod_d;
  logic [DvdW-1:0]  div_q, div_d;
  logic [RateW-1:0] keep_rate_q, keep_rate_d;
  logic [CodeW-1:0] keep_code_q, keep_code_d;
  logic [DvdW-1:0]  keep_dvd_q, keep_dvd_d;
  logic             mval_q, mval_d;
  logic [71:0]      mdata_q, mdata_d;
  logic             mfound_q, mfound_d;
  logic             found;
  logic [WordW-1:0] word;
  logic             in_band;
  div_req_t         dreq;
  div_rsp_t         drsp;

  pmds_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (dreq),
    .rsp_o  (drsp)
  );

  assign in_band = (s_axis_tdata >= RateMin) && (s_axis_tdata <= RateMax);
  assign found   = keep_rate_q != '0;
  assign word    = {sel_q, 7'd0, keep_code_q, StartupCount, keep_dvd_q};

  always_comb begin
    state_d       = state_q;
    target_d      = target_q;
    sel_d         = sel_q;
    code_d        = code_q;
    prod_d        = prod_q;
    div_d         = div_q;
    keep_rate_d   = keep_rate_q;
    keep_code_d   = keep_code_q;
    keep_dvd_d    = keep_dvd_q;
    mval_d        = mval_q && !m_axis_tready;
    mdata_d       = mdata_q;
    mfound_d      = mfound_q;
    s_axis_tready = 1'b0;
    dreq.start    = 1'b0;
    dreq.dividend = (state_q == ST_Q1) ? prod_q - 1'b1 : prod_q;
    dreq.divisor  = (state_q == ST_Q1) ? target_q : {{(DivW-DvdW){1'b0}}, div_q};
    unique case (state_q)
      ST_IDLE: begin
        s_axis_tready = 1'b1;
        if (s_axis_tvalid) begin
          target_d    = s_axis_tdata;
          sel_d       = s_axis_tuser;
          code_d      = MulFirst;
          prod_d      = {{(DivW-MainW-3){1'b0}}, mcr_q, 3'b000};
          keep_rate_d = '0;
          keep_code_d = '0;
          keep_dvd_d  = '0;
          state_d     = in_band ? ST_Q1 : ST_DONE;
        end
      end
      ST_Q1: begin
        dreq.start = 1'b1;
        state_d    = ST_W1;
      end
      ST_W1: begin
        if (drsp.done) begin
          if (drsp.quot >= DivMax) begin
            state_d = ST_NEXT;
          end else begin
            div_d   = drsp.quot[DvdW-1:0] + 1'b1;
            state_d = ST_Q2;
          end
        end
      end
      ST_Q2: begin
        dreq.start = 1'b1;
        state_d    = ST_W2;
      end
      ST_W2: begin
        if (drsp.done) begin
          if (drsp.quot == target_q) begin
            keep_rate_d = drsp.quot[RateW-1:0];
            keep_code_d = code_q;
            keep_dvd_d  = div_q;
            state_d     = ST_DONE;
          end else begin
            if (drsp.quot < target_q && drsp.quot >= RateMin
                && drsp.quot[RateW-1:0] > keep_rate_q) begin
              keep_rate_d = drsp.quot[RateW-1:0];
              keep_code_d = code_q;
              keep_dvd_d  = div_q;
            end
            state_d = ST_NEXT;
          end
        end
      end
      ST_NEXT: begin
        if (code_q == MulLast) begin
          state_d = ST_DONE;
        end else begin
          code_d  = code_q + 1'b1;
          prod_d  = prod_q + {{(DivW-MainW){1'b0}}, mcr_q};
          state_d = ST_Q1;
        end
      end
      ST_DONE: begin
        if (!mval_q || m_axis_tready) begin
          mval_d   = 1'b1;
          mfound_d = found;
          mdata_d  = found ? {word, keep_dvd_q, keep_code_q, keep_rate_q} : '0;
          state_d  = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      mcr_q   <= MainRateReset;
      mval_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      mval_q  <= mval_d;
      if (cfg_we_i) begin
        mcr_q <= cfg_wdata_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    target_q    <= target_d;
    sel_q       <= sel_d;
    code_q      <= code_d;
    prod_q      <= prod_d;
    div_q       <= div_d;
    keep_rate_q <= keep_rate_d;
    keep_code_q <= keep_code_d;
    keep_dvd_q  <= keep_dvd_d;
    mdata_q     <= mdata_d;
    mfound_q    <= mfound_d;
  end

  assign m_axis_tvalid = mval_q;
  assign m_axis_tdata  = mdata_q;
  assign m_axis_tuser  = mfound_q;

  `PMDS_ASSERT_IMP(a_found_in_band, clk_i, rst_ni, m_axis_tvalid && m_axis_tuser,
                   m_axis_tdata[27:0] >= RateMin[27:0] && m_axis_tdata[27:0] <= RateMax[27:0])
  `PMDS_ASSERT_IMP(a_none_zero, clk_i, rst_ni, m_axis_tvalid && !m_axis_tuser,
                   m_axis_tdata == '0)
  `PMDS_ASSERT_IMP(a_start_in_search, clk_i, rst_ni, dreq.start,
                   state_q == ST_Q1 || state_q == ST_Q2)
  `PMDS_ASSERT_IMP(a_best_below_target, clk_i, rst_ni, state_q == ST_NEXT,
                   DivW'(keep_rate_q) <= target_q)

endmodule

`default_nettype wire

// ===== tb/pll_mul_div_search_checker.sv =====
// Checker for the PLL multiplier/divider search unit: tracks the main clock rate register,
// predicts the setting for every accepted request and compares each result field by field.
// Depends on pmds_pkg for widths and search limits.
`timescale 1ns / 100ps

module pll_mul_div_search_checker import pmds_pkg::*; (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             cfg_we_i,
  input  wire logic [MainW-1:0] cfg_wdata_i,
  input  wire logic             s_axis_tvalid_i,
  input  wire logic             s_axis_tready_i,
  input  wire logic [31:0]      s_axis_tdata_i,  // [31:0] target_rate
  input  wire logic             s_axis_tuser_i,  // [0] pll_a_select
  input  wire logic             m_axis_tvalid_i,
  input  wire logic             m_axis_tready_i,
  input  wire logic [71:0]      m_axis_tdata_i,  // [27:0] achieved_rate, [33:28] multiplier,
                                                 // [41:34] divider, [71:42] settings_word
  input  wire logic             m_axis_tuser_i,  // [0] found
  output int                    mismatches_o,
  output int                    outstanding_o
);

  localparam int unsigned StartupPos = 8;
  localparam int unsigned MulPos     = 16;
  localparam int unsigned PllAPos    = 29;

  typedef struct packed {
    logic [RateW-1:0] achieved_rate;
    logic [CodeW-1:0] multiplier;
    logic [DvdW-1:0]  divider;
    logic             found;
    logic [WordW-1:0] settings_word;
  } pll_setting_t;

  logic [31:0]  main_rate;
  pll_setting_t expected_settings[$];

  function automatic pll_setting_t search_pll_setting(input logic [31:0] target,
                                                      input logic sel_a,
                                                      input logic [31:0] main_hz);
    pll_setting_t res;
    logic [31:0]  prod, dvd, got, keep_rate, keep_code, keep_dvd;
    int unsigned  code;
    res       = '0;
    keep_rate = '0;
    keep_code = '0;
    keep_dvd  = '0;
    if (target < RateMin || target > RateMax) return res;
    for (code = MulFirst; code <= MulLast; code++) begin
      prod = main_hz * 32'(code + 1);
      dvd  = 32'd1 + (prod - 32'd1) / target;
      if (dvd == 32'd0 || dvd > DivMax) continue;
      got = prod / dvd;
      if (got == target) begin
        keep_rate = got;
        keep_code = 32'(code);
        keep_dvd  = dvd;
        break;
      end
      if (got > target || got < RateMin || got > RateMax) continue;
      if (target - got < target - keep_rate) begin
        keep_rate = got;
        keep_code = 32'(code);
        keep_dvd  = dvd;
      end
    end
    if (keep_rate != 32'd0) begin
      res.achieved_rate = keep_rate[RateW-1:0];
      res.multiplier    = keep_code[CodeW-1:0];
      res.divider       = keep_dvd[DvdW-1:0];
      res.found         = 1'b1;
      res.settings_word = WordW'(keep_dvd | (32'(StartupCount) << StartupPos)
                                 | (keep_code << MulPos) | (32'(sel_a) << PllAPos));
    end
    return res;
  endfunction

  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] seen);
    if (want !== seen) begin
      $display("%0t: %s expected %0d (0x%h), got %0d (0x%h)",
               $time, name, want, want, seen, seen);
      mismatches_o++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin : watch
    pll_setting_t want, seen;
    if (!rst_ni) begin
      main_rate = 32'(MainRateReset);
      expected_settings.delete();
      mismatches_o  = 0;
      outstanding_o = 0;
    end else begin
      if (cfg_we_i) main_rate = 32'(cfg_wdata_i);
      if (m_axis_tvalid_i && m_axis_tready_i) begin
        seen.achieved_rate = m_axis_tdata_i[27:0];
        seen.multiplier    = m_axis_tdata_i[33:28];
        seen.divider       = m_axis_tdata_i[41:34];
        seen.settings_word = m_axis_tdata_i[71:42];
        seen.found         = m_axis_tuser_i;
        if (expected_settings.size() == 0) begin
          $display("%0t: result with none expected, expected nothing, got tdata 0x%h tuser %b",
                   $time, m_axis_tdata_i, m_axis_tuser_i);
          mismatches_o++;
        end else begin
          want = expected_settings.pop_front();
          check_field("achieved_rate", 32'(want.achieved_rate), 32'(seen.achieved_rate));
          check_field("multiplier", 32'(want.multiplier), 32'(seen.multiplier));
          check_field("divider", 32'(want.divider), 32'(seen.divider));
          check_field("found", 32'(want.found), 32'(seen.found));
          check_field("settings_word", 32'(want.settings_word), 32'(seen.settings_word));
        end
      end
      if (s_axis_tvalid_i && s_axis_tready_i)
        expected_settings.push_back(search_pll_setting(s_axis_tdata_i, s_axis_tuser_i,
                                                       main_rate));
      outstanding_o = expected_settings.size();
    end
  end

endmodule

// ===== tb/pll_mul_div_search_unit_tb.sv =====
// Testbench top for the PLL multiplier/divider search unit: clock, reset, request stimulus,
// result back-pressure and the verdict. Depends on pmds_pkg, the unit and its checker.
`timescale 1ns / 100ps

module pll_mul_div_search_unit_tb;
  import pmds_pkg::*;

  localparam int unsigned RandomItems    = 140;
  localparam int unsigned PhaseItems     = 40;
  localparam int unsigned HoldAfter      = 25;
  localparam int unsigned SinkHoldCycles = 15000;
  localparam int unsigned SinkCalmFrom   = 70;
  localparam int unsigned SinkCalmTo     = 110;
  localparam int unsigned SettleCycles   = 8;
  localparam int unsigned CycleLimit     = 4000000;

  logic             clk_i = 1'b0;
  logic             rst_ni;
  logic             cfg_we_i;
  logic [MainW-1:0] cfg_wdata_i;
  logic             s_axis_tvalid;
  logic             s_axis_tready;
  logic [31:0]      s_axis_tdata;
  logic             s_axis_tuser;
  logic             m_axis_tvalid;
  logic             m_axis_tready;
  logic [71:0]      m_axis_tdata;
  logic             m_axis_tuser;

  int               mismatches;
  int               outstanding;
  int unsigned      cycle_count = 0;
  bit               src_calm = 1'b0;
  logic [31:0]      main_rate;

  always #6 clk_i = ~clk_i;

  pll_mul_div_search_unit dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  pll_mul_div_search_checker checker_i (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_wdata_i     (cfg_wdata_i),
    .s_axis_tvalid_i (s_axis_tvalid),
    .s_axis_tready_i (s_axis_tready),
    .s_axis_tdata_i  (s_axis_tdata),
    .s_axis_tuser_i  (s_axis_tuser),
    .m_axis_tvalid_i (m_axis_tvalid),
    .m_axis_tready_i (m_axis_tready),
    .m_axis_tdata_i  (m_axis_tdata),
    .m_axis_tuser_i  (m_axis_tuser),
    .mismatches_o    (mismatches),
    .outstanding_o   (outstanding)
  );

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CycleLimit) begin
      $display("pll_mul_div_search_unit: mismatch");
      $finish;
    end
  end

  task automatic send_request(input logic [31:0] target, input logic sel_a);
    while (!src_calm && $urandom_range(99) < 32) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= target;
    s_axis_tuser  <= sel_a;
    do @(posedge clk_i); while (!s_axis_tready);
    @(negedge clk_i);
  endtask

  task automatic wait_for_results();
    s_axis_tvalid <= 1'b0;
    @(negedge clk_i);
    while (outstanding != 0) @(negedge clk_i);
    repeat (SettleCycles) @(negedge clk_i);
  endtask

  task automatic write_main_rate(input logic [MainW-1:0] rate_hz);
    cfg_wdata_i <= rate_hz;
    cfg_we_i    <= 1'b1;
    main_rate    = 32'(rate_hz);
    @(negedge clk_i);
    cfg_we_i    <= 1'b0;
  endtask

  initial begin : sink
    int unsigned taken;
    bit          held;
    taken = 0;
    held  = 1'b0;
    m_axis_tready = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (!held && taken >= HoldAfter) begin
        held = 1'b1;
        m_axis_tready <= 1'b0;
        repeat (SinkHoldCycles) @(negedge clk_i);
      end
      if (taken >= SinkCalmFrom && taken < SinkCalmTo) m_axis_tready <= 1'b1;
      else m_axis_tready <= ($urandom_range(99) >= 32);
      @(posedge clk_i);
      if (m_axis_tvalid && m_axis_tready) taken++;
    end
  end

  initial begin : stimulus
    logic [31:0] target;
    int unsigned pick, code, dvd, n;
    rst_ni        = 1'b0;
    cfg_we_i      = 1'b0;
    cfg_wdata_i   = '0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = 1'b0;
    main_rate     = 32'(MainRateReset);
    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    send_request(32'd0, 1'b0);
    send_request(RateMin - 32'd1, 1'b1);
    send_request(RateMin, 1'b0);
    send_request(RateMax, 1'b1);
    send_request(RateMax + 32'd1, 1'b0);
    send_request(32'hFFFF_FFFF, 1'b1);
    send_request(32'd96000000, 1'b1);
    send_request(32'd123456789, 1'b0);
    send_request(32'd200000000, 1'b1);
    wait_for_results();

    write_main_rate('0);
    send_request(32'd100000000, 1'b1);
    send_request(RateMax, 1'b0);
    wait_for_results();

    write_main_rate('1);
    send_request(RateMin, 1'b1);
    send_request(RateMax, 1'b0);
    send_request(32'd160000000, 1'b1);
    wait_for_results();

    write_main_rate(MainW'(60000000));
    send_request(RateMin, 1'b0);
    send_request(RateMax, 1'b1);
    send_request(32'd150000000, 1'b0);
    wait_for_results();

    write_main_rate(MainW'(1));
    send_request(RateMin, 1'b1);
    wait_for_results();

    write_main_rate(MainW'(3000000));
    send_request(32'd81000000, 1'b0);
    send_request(32'd239999999, 1'b1);

    for (n = 0; n < RandomItems; n++) begin
      if (n % PhaseItems == 0) begin
        wait_for_results();
        case (n / PhaseItems)
          0:       write_main_rate(MainRateReset);
          2:       write_main_rate(MainW'($urandom_range((1 << MainW) - 1, 0)));
          default: write_main_rate(MainW'($urandom_range(60000000, 1000000)));
        endcase
      end
      src_calm = (n >= 45 && n < 75);
      pick = $urandom_range(99);
      if (pick < 12) begin
        target = $urandom;
      end else if (pick < 16) begin
        target = $urandom_range(1) ? RateMax + 32'd1 : RateMin - 32'd1;
      end else if (pick < 36) begin
        code   = $urandom_range(MulLast, MulFirst);
        dvd    = $urandom_range(255, 1);
        target = main_rate * 32'(code + 1) / 32'(dvd);
        if (target < RateMin || target > RateMax) target = $urandom_range(RateMax, RateMin);
      end else begin
        target = $urandom_range(RateMax, RateMin);
      end
      send_request(target, 1'($urandom_range(1)));
    end
    src_calm = 1'b0;
    wait_for_results();

    if (mismatches == 0) begin
      $display("pll_mul_div_search_unit: match");
    end else begin
      $display("pll_mul_div_search_unit: mismatch");
    end
    $finish;
  end

endmodule
